// ===== hdl/nearest_centroid_assign_assert.svh =====
// Assertion macros used by the checker file of the block.
`ifndef NEAREST_CENTROID_ASSIGN_ASSERT_SVH
`define NEAREST_CENTROID_ASSIGN_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NCA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nearest_centroid_assign: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define NCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nearest_centroid_assign: next-cycle check failed");

`endif

// ===== hdl/nca_pkg.sv =====
package nca_pkg;

  localparam int NUM_GROUPS   = 32;
  localparam int NUM_FEATURES = 64;

  localparam int GRP_IDX_W   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int GRP_CNT_W   = $clog2(NUM_GROUPS + 1);
  localparam int STORE_DEPTH = NUM_GROUPS * NUM_FEATURES;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int VAL_W = 16;
  localparam int SQ_W  = 32;
  localparam int ACC_W = 40;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_ELEM = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_HOLD
  } state_e;

  typedef struct packed {
    opcode_e            opcode;
    logic [4:0]         group_index;
    logic [5:0]         feature_index;
    logic signed [15:0] feature_value;
    logic               last_feature;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  nearest_group;
    logic [39:0] min_distance_sq;
  } out_word_t;

endpackage

// ===== hdl/nca_ram.sv =====
module nca_ram #(
  parameter int Width = 16,
  parameter int Depth = 2048
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/nca_sqdiff.sv =====
module nca_sqdiff (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              vld_i,
  input  logic                              en_i,
  input  logic signed [nca_pkg::VAL_W-1:0]  cen_i,
  input  logic signed [nca_pkg::VAL_W-1:0]  val_i,
  output logic                              vld_o,
  output logic [nca_pkg::SQ_W-1:0]          sq_o
);
  import nca_pkg::*;

  logic [VAL_W:0]   diff;
  logic [VAL_W:0]   mag_full;
  logic [VAL_W-1:0] mag;
  logic [SQ_W-1:0]  prod;
  logic             vld_q;
  logic [SQ_W-1:0]  sq_q;

  // The magnitude of a 17-bit difference of two 16-bit values fits in 16 bits.
  always_comb begin
    diff     = {cen_i[VAL_W-1], cen_i} - {val_i[VAL_W-1], val_i};
    mag_full = diff[VAL_W] ? (~diff + (VAL_W+1)'(1)) : diff;
    mag      = mag_full[VAL_W-1:0];
    prod     = SQ_W'(mag) * SQ_W'(mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= en_i ? prod : '0;
  end

  assign vld_o = vld_q;
  assign sq_o  = sq_q;

endmodule

// ===== hdl/nca_cell.sv =====
module nca_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       shift_i,
  input  logic [nca_pkg::ACC_W-1:0]  acc_i,
  output logic [nca_pkg::ACC_W-1:0]  acc_o
);
  import nca_pkg::*;

  logic [ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (shift_i) begin
      acc_q <= acc_i;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== hdl/nearest_centroid_assign.sv =====
// Nearest-centroid assignment for k-means, by squared Euclidean distance.
// The input channel takes one word per handshake (in_valid_i high, in_stall_o
// low). A load word (opcode 0) writes one centroid feature into the centroid
// memory and is taken without stalling; the block is ready again at once.
// An element word (opcode 1) sweeps all NUM_GROUPS accumulators, and the
// input stays stalled for the whole sweep. A word marked last_feature keeps
// the input stalled after its sweep until its result moves into the output
// register. The sweep length is set by the single squared-difference unit,
// which visits one group per cycle, fed by the one read port of the centroid
// memory.
// The result word (nearest group and its distance) is loaded from the hold
// state after the sweep of the last element word. While out_stall_i is high
// it holds; the block keeps taking words, but a second result waits inside
// with the input stalled until the first result is taken.
// Reset clears the accumulators and all control state. The centroid memory is
// not cleared: every centroid feature must be loaded before it is used.
module nearest_centroid_assign (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  nca_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nca_pkg::out_word_t out_word_o
);
  import nca_pkg::*;

  state_e state_q, state_d;

  logic in_accept;
  logic grp_ok, feat_ok;
  logic load_we, elem_start;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  // Element currently being swept.
  logic [5:0]              feat_q;
  logic signed [VAL_W-1:0] val_q;
  logic                    last_q;
  logic                    feat_ok_q;

  logic [GRP_CNT_W-1:0] rd_cnt_q;
  logic                 rd_issue;
  logic                 rd_vld_q;
  logic [VAL_W-1:0]     cen_data;

  logic              sq_vld;
  logic [SQ_W-1:0]   sq;

  // The accumulator ring: cell 0 is the head, the updated value enters at the
  // tail, and after one full sweep every group is back in its own cell.
  logic [ACC_W-1:0] acc_w [NUM_GROUPS];
  logic [ACC_W-1:0] tail_acc;
  logic [ACC_W:0]   sum;
  logic [ACC_W-1:0] new_acc;

  logic [GRP_IDX_W-1:0] head_idx_q;
  logic                 pass_end;

  logic [GRP_IDX_W-1:0] best_idx_q;
  logic [ACC_W-1:0]     best_sum_q;

  logic      out_free;
  logic      out_load;
  logic      out_valid_q;
  out_word_t out_word_q;

  assign in_accept = in_valid_i && !in_stall_o;

  // Loads outside the store are dropped.
  assign grp_ok     = 32'(in_word_i.group_index) < 32'(NUM_GROUPS);
  assign feat_ok    = 32'(in_word_i.feature_index) < 32'(NUM_FEATURES);
  assign load_we    = in_accept && (in_word_i.opcode == OP_LOAD) && grp_ok && feat_ok;
  assign elem_start = in_accept && (in_word_i.opcode == OP_ELEM);

  assign wr_addr = ADDR_W'(32'(in_word_i.group_index) * 32'(NUM_FEATURES)
                           + 32'(in_word_i.feature_index));

  always_ff @(posedge clk_i) begin
    if (elem_start) begin
      feat_q    <= in_word_i.feature_index;
      val_q     <= in_word_i.feature_value;
      feat_ok_q <= feat_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
    end else if (elem_start) begin
      last_q <= in_word_i.last_feature;
    end
  end

  // One centroid read per cycle, group by group, for the current column.
  assign rd_issue = (state_q == ST_SWEEP) && (rd_cnt_q < GRP_CNT_W'(NUM_GROUPS));
  assign rd_addr  = ADDR_W'(32'(rd_cnt_q[GRP_IDX_W-1:0]) * 32'(NUM_FEATURES) + 32'(feat_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_issue;
      if (elem_start) begin
        rd_cnt_q <= '0;
      end else if (rd_issue) begin
        rd_cnt_q <= rd_cnt_q + GRP_CNT_W'(1);
      end
    end
  end

  nca_ram #(
    .Width(VAL_W),
    .Depth(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (load_we),
    .waddr_i(wr_addr),
    .wdata_i(in_word_i.feature_value),
    .raddr_i(rd_addr),
    .rdata_o(cen_data)
  );

  // An out-of-range column contributes zero to every group.
  nca_sqdiff u_sqdiff (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (rd_vld_q),
    .en_i  (feat_ok_q),
    .cen_i (signed'(cen_data)),
    .val_i (val_q),
    .vld_o (sq_vld),
    .sq_o  (sq)
  );

  // Saturating add at the head of the ring.
  always_comb begin
    sum     = {1'b0, acc_w[0]} + (ACC_W+1)'(sq);
    new_acc = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    // The sweep of a last feature also clears the ring behind it.
    tail_acc = last_q ? '0 : new_acc;
  end

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_cell
    if (g == NUM_GROUPS - 1) begin : g_tail
      nca_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(sq_vld),
        .acc_i  (tail_acc),
        .acc_o  (acc_w[g])
      );
    end else begin : g_body
      nca_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(sq_vld),
        .acc_i  (acc_w[g+1]),
        .acc_o  (acc_w[g])
      );
    end
  end

  assign pass_end = sq_vld && (head_idx_q == GRP_IDX_W'(NUM_GROUPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx_q <= '0;
    end else if (sq_vld) begin
      head_idx_q <= pass_end ? '0 : head_idx_q + GRP_IDX_W'(1);
    end
  end

  // Running minimum over the sweep. Only a strictly smaller sum replaces the
  // current best, so the lowest group index wins a tie.
  always_ff @(posedge clk_i) begin
    if (sq_vld && ((head_idx_q == '0) || (new_acc < best_sum_q))) begin
      best_idx_q <= head_idx_q;
      best_sum_q <= new_acc;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (elem_start) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (pass_end) begin
          state_d = last_q ? ST_HOLD : ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Output logic.
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:  in_stall_o = 1'b0;
      ST_SWEEP: in_stall_o = 1'b1;
      ST_HOLD:  out_load   = out_free;
      default:  in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q.nearest_group   <= 5'(best_idx_q);
      out_word_q.min_distance_sq <= best_sum_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== hdl/nca_chk.sv =====
`include "nearest_centroid_assign_assert.svh"

module nca_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input nca_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input nca_pkg::out_word_t out_word_o
);
  import nca_pkg::*;

  // A result word that is not taken stays on the port unchanged.
  `NCA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o))

  // An element word always starts a sweep that blocks the input.
  `NCA_ASSERT_NEXT(a_elem_busy, in_valid_i && !in_stall_o && in_word_i.opcode == OP_ELEM,
                   in_stall_o)

  // A load word finishes in its own cycle.
  `NCA_ASSERT_NEXT(a_load_quick, in_valid_i && !in_stall_o && in_word_i.opcode == OP_LOAD,
                   !in_stall_o)

  // A new result only appears at the end of a sweep, while the input is held.
  `NCA_ASSERT_SAME(a_out_from_sweep, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind nearest_centroid_assign nca_chk u_nca_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_word_i  (in_word_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);

// ===== dv/tb_nearest_centroid_assign.sv =====
`timescale 1ns / 1ps

module tb_nearest_centroid_assign;
  import nca_pkg::*;

  // Longest stretch with no word accepted on either channel before the run
  // is declared hung. An element sweep plus the worst receiver stall stays
  // far below this.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SWEEP_CYCLES   = NUM_GROUPS + 3;
  // Element features only use the first columns, and those are loaded for
  // every group.
  localparam int USED_COLS      = 8;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  nearest_centroid_assign u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the centroid memory and of the per-group distance sums.
  logic signed [VAL_W-1:0] cent_mem [STORE_DEPTH];
  logic [ACC_W-1:0]        dist_acc [NUM_GROUPS];

  // Nearest-group answers still owed by the block, oldest first.
  out_word_t nearest_q [$];

  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        err_cnt       = 0;
  int        quiet_cycles  = 0;
  out_word_t want_word;

  // Applies one accepted word to the shadow state. A load updates the
  // centroid copy; an element feature adds its squared difference to every
  // group's sum, and a last mark closes the element with a search for the
  // smallest sum (strict less, so the lowest group wins a tie).
  task automatic accumulate_distances(input in_word_t w);
    int              idx;
    int              diff;
    longint unsigned mag;
    logic [63:0]     sum;
    int              best;
    logic [ACC_W-1:0] best_d;
    out_word_t       res;
    if (w.opcode == OP_LOAD) begin
      // A last mark on a load does nothing.
      if (w.group_index < NUM_GROUPS && w.feature_index < NUM_FEATURES) begin
        cent_mem[int'(w.group_index) * NUM_FEATURES + int'(w.feature_index)] = w.feature_value;
      end
      return;
    end
    if (w.feature_index < NUM_FEATURES) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        idx  = g * NUM_FEATURES + int'(w.feature_index);
        diff = int'(cent_mem[idx]) - int'(w.feature_value);
        mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
        sum  = {24'd0, dist_acc[g]} + mag * mag;
        // Sums clamp at the top of the 40-bit range.
        dist_acc[g] = (sum > {24'd0, ACC_MAX}) ? ACC_MAX : sum[ACC_W-1:0];
      end
    end
    if (!w.last_feature) return;
    best   = 0;
    best_d = dist_acc[0];
    for (int g = 1; g < NUM_GROUPS; g++) begin
      if (dist_acc[g] < best_d) begin
        best   = g;
        best_d = dist_acc[g];
      end
    end
    res.nearest_group   = best[4:0];
    res.min_distance_sq = best_d;
    nearest_q.push_back(res);
    for (int g = 0; g < NUM_GROUPS; g++) dist_acc[g] = '0;
  endtask

  function automatic in_word_t make_word(input opcode_e op, input logic [4:0] grp,
                                         input logic [5:0] col,
                                         input logic signed [15:0] val, input logic last);
    in_word_t w;
    w.opcode        = op;
    w.group_index   = grp;
    w.feature_index = col;
    w.feature_value = val;
    w.last_feature  = last;
    return w;
  endfunction

  // Feature values lean toward the ends of the Q8.8 range and zero.
  function automatic logic signed [15:0] draw_feature();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Sends one word. The sender may first idle for a few cycles; valid then
  // stays high until the word is taken, and is left high so that a following
  // word can go out back to back.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    accumulate_distances(w);
  endtask

  // Holds the input channel quiet until every owed result has arrived.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (nearest_q.size() != 0) @(posedge clk_i);
  endtask

  // Loads every group in the columns that element features use, so that no
  // element feature can ever read an entry that was never written.
  task automatic test_load_centroids();
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int f = 0; f < USED_COLS; f++) begin
        send_word(make_word(OP_LOAD, 5'(g), 6'(f), draw_feature(), 1'($urandom_range(1))));
      end
    end
  endtask

  // Extreme differences in both directions, and an exact match.
  task automatic test_extremes();
    for (int g = 0; g < NUM_GROUPS; g++) begin
      send_word(make_word(OP_LOAD, 5'(g), 6'd0, (g == 7) ? 16'sh7FFF : 16'sh8000, 1'b0));
    end
    send_word(make_word(OP_ELEM, 5'd31, 6'd0, 16'sh7FFF, 1'b1));
    send_word(make_word(OP_ELEM, 5'd0, 6'd0, 16'sh8000, 1'b1));
    send_word(make_word(OP_ELEM, 5'd21, 6'd0, 16'sh0000, 1'b1));
  endtask

  // All groups equal, then two equal winners in the middle of the range:
  // the lower group has to be reported both times.
  task automatic test_ties();
    for (int g = 0; g < NUM_GROUPS; g++) begin
      send_word(make_word(OP_LOAD, 5'(g), 6'd1, 16'sd100, 1'b0));
    end
    send_word(make_word(OP_ELEM, 5'd10, 6'd1, 16'sd100, 1'b1));
    send_word(make_word(OP_LOAD, 5'd25, 6'd1, 16'sd50, 1'b0));
    send_word(make_word(OP_LOAD, 5'd20, 6'd1, 16'sd50, 1'b0));
    send_word(make_word(OP_ELEM, 5'd3, 6'd1, 16'sd40, 1'b1));
  endtask

  // A load carrying a last mark must not close the element in progress.
  task automatic test_load_marked_last();
    send_word(make_word(OP_ELEM, 5'd0, 6'd5, -16'sd1234, 1'b0));
    send_word(make_word(OP_LOAD, 5'd4, 6'd5, 16'sd1234, 1'b1));
    send_word(make_word(OP_ELEM, 5'd9, 6'd5, 16'sd1234, 1'b1));
  endtask

  // The same column fed several times within one element.
  task automatic test_repeated_columns();
    send_word(make_word(OP_ELEM, 5'd1, 6'd2, 16'sh0A00, 1'b0));
    send_word(make_word(OP_ELEM, 5'd2, 6'd2, -16'sh0A00, 1'b0));
    send_word(make_word(OP_ELEM, 5'd3, 6'd2, 16'sh0A00, 1'b1));
  endtask

  // With every centroid at the low end and the element at the high end,
  // 257 features push every sum past the 40-bit limit, so all of them clamp
  // and group 0 wins with the clamped value.
  task automatic test_saturation();
    for (int g = 0; g < NUM_GROUPS; g++) begin
      send_word(make_word(OP_LOAD, 5'(g), 6'd3, 16'sh8000, 1'b0));
    end
    for (int n = 0; n < 257; n++) begin
      send_word(make_word(OP_ELEM, 5'($urandom_range(31)), 6'd3, 16'sh7FFF, n == 256));
    end
  endtask

  // Mostly whole elements of random length and content, sometimes close to
  // a stored centroid, with loads mixed in between and within elements.
  // The rest is stray loads and lone element features whose last mark is
  // random, so that they run into the next element.
  task automatic test_random(input int n_items, input int snd_pct, input int rcv_pct);
    int  sent;
    int  len;
    int  col;
    int  grp;
    bit  paused;
    logic signed [15:0] val;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      case ($urandom_range(19))
        0, 1: begin
          send_word(make_word(OP_LOAD, 5'($urandom_range(31)), 6'($urandom_range(USED_COLS - 1)),
                              draw_feature(), 1'($urandom_range(1))));
          sent++;
        end
        2: begin
          send_word(make_word(OP_ELEM, 5'($urandom_range(31)), 6'($urandom_range(USED_COLS - 1)),
                              draw_feature(), 1'($urandom_range(1))));
          sent++;
        end
        default: begin
          len = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
          for (int n = 0; n < len; n++) begin
            if ($urandom_range(9) == 0) begin
              send_word(make_word(OP_LOAD, 5'($urandom_range(31)),
                                  6'($urandom_range(USED_COLS - 1)),
                                  draw_feature(), 1'($urandom_range(1))));
              sent++;
            end
            col = $urandom_range(USED_COLS - 1);
            grp = $urandom_range(31);
            if ($urandom_range(2) == 0) begin
              val = 16'(cent_mem[grp * NUM_FEATURES + col] + ($urandom_range(6) - 3));
            end else begin
              val = draw_feature();
            end
            send_word(make_word(OP_ELEM, 5'($urandom_range(31)), 6'(col), val, n == len - 1));
            sent++;
          end
        end
      endcase
      if (!paused && sent >= n_items / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
    end
  endtask

  // Result checking, and the receiver's stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (nearest_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("unexpected result word: group %0d distance %0d",
                   out_word_o.nearest_group, out_word_o.min_distance_sq);
        end
      end else begin
        want_word = nearest_q.pop_front();
        if (out_word_o.nearest_group !== want_word.nearest_group ||
            out_word_o.min_distance_sq !== want_word.min_distance_sq) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("result mismatch: group exp %0d got %0d, distance exp %0d got %0d",
                     want_word.nearest_group, out_word_o.nearest_group,
                     want_word.min_distance_sq, out_word_o.min_distance_sq);
          end
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: any handshake on either channel shows progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < WATCHDOG_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int g = 0; g < NUM_GROUPS; g++) dist_acc[g] = '0;
    for (int i = 0; i < STORE_DEPTH; i++) cent_mem[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed tests run with the first idling mix.
    send_idle_pct = 28;
    recv_idle_pct = 48;
    test_load_centroids();
    test_extremes();
    test_ties();
    test_load_marked_last();
    test_repeated_columns();
    test_saturation();

    test_random(225, 28, 48);
    test_random(225, 48, 28);
    test_random(225, 0, 0);

    // Drain, then give the block time to show any stray result word.
    wait_for_results();
    repeat (2 * SWEEP_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && nearest_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
